/* sv/cwqnco_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register map and sine table generator for the quadrature NCO.
package cwqnco_pkg;

    // Default design parameters
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_TABLE_ADDR_BITS = 10;
    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_COUNT_BITS      = 24;

    // Register field widths
    localparam int STEP_BITS = 32;
    localparam int AMP_BITS  = 15;
    localparam int LEN_BITS  = 24;

    // Stream and APB port widths
    localparam int IN_DATA_BITS  = 8;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_BITS-1:0] REG_PHASE_STEP    = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_AMPLITUDE     = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_PACKET_LENGTH = REG_IDX_BITS'(2);

    // Register reset values
    localparam logic [STEP_BITS-1:0] RST_PHASE_STEP    = '0;
    localparam logic [AMP_BITS-1:0]  RST_AMPLITUDE     = AMP_BITS'(32767);
    localparam logic [LEN_BITS-1:0]  RST_PACKET_LENGTH = LEN_BITS'(1024);

    // pi/2 in Q2.30
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam int     Q30_SHIFT   = 30;

    // Rounded Q2.30 product of two nonnegative operands below 2^31
    function automatic longint q30_mul(input longint a, input longint b);
        longint p;
        p = a * b + (longint'(1) <<< (Q30_SHIFT - 1));
        return p >>> Q30_SHIFT;
    endfunction

    // Quarter-wave sine entry k, scaled to 2^(sample_bits-1)-1; elaboration only
    function automatic longint sine_entry(input longint k, input int addr_bits,
                                          input int sample_bits);
        longint amax;
        longint x;
        longint term;
        longint sum;
        longint v;
        amax = (longint'(1) <<< (sample_bits - 1)) - 1;
        x    = (HALF_PI_Q30 * k + (longint'(1) <<< (addr_bits - 1))) >>> addr_bits;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = q30_mul(q30_mul(term, x), x);
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                7:       term = term / 210;
                default: term = term / 272;
            endcase
            if (n % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum * amax + (longint'(1) <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
        return (v > amax) ? amax : v;
    endfunction

endpackage

/* sv/cwqnco_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
module cwqnco_ram #(
    parameter int WIDTH = cwqnco_pkg::DEF_SAMPLE_BITS - 1,
    parameter int DEPTH = (1 << cwqnco_pkg::DEF_TABLE_ADDR_BITS) + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

/* sv/cwqnco_table.sv */
`timescale 1ns / 1ps
// Quarter-wave sine table: RAM loaded by a sweep after reset, two read ports.
module cwqnco_table #(
    parameter int TABLE_ADDR_BITS = cwqnco_pkg::DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = cwqnco_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [TABLE_ADDR_BITS:0]   rd_addr_a,
    input  logic [TABLE_ADDR_BITS:0]   rd_addr_b,
    output logic [SAMPLE_BITS-2:0]     rd_data_a,
    output logic [SAMPLE_BITS-2:0]     rd_data_b,
    output logic                       fill_done
);
    import cwqnco_pkg::*;

    localparam int DEPTH      = (1 << TABLE_ADDR_BITS) + 1;
    localparam int IDX_BITS   = TABLE_ADDR_BITS + 1;
    localparam int ENTRY_BITS = SAMPLE_BITS - 1;

    typedef logic [ENTRY_BITS-1:0] qwave_t [DEPTH];

    function automatic qwave_t build_qwave();
        qwave_t tbl;
        for (int k = 0; k < DEPTH; k++)
        begin
            tbl[k] = ENTRY_BITS'(sine_entry(longint'(k), TABLE_ADDR_BITS, SAMPLE_BITS));
        end
        return tbl;
    endfunction

    localparam qwave_t QWAVE = build_qwave();

    logic [IDX_BITS-1:0] fill_cnt_reg;
    logic [IDX_BITS-1:0] fill_cnt_next;
    logic                fill_we;

    assign fill_done     = (fill_cnt_reg == IDX_BITS'(DEPTH));
    assign fill_we       = !fill_done;
    assign fill_cnt_next = fill_we ? fill_cnt_reg + IDX_BITS'(1) : fill_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
        end
        else
        begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    cwqnco_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (fill_we),
        .waddr   (fill_cnt_reg),
        .wdata   (QWAVE[fill_cnt_reg]),
        .re      (rd_en),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd_data_a),
        .rdata_b (rd_data_b)
    );
endmodule

/* sv/cw_quadrature_nco_generator.sv */
`timescale 1ns / 1ps
// Quadrature NCO: phase accumulator, quarter-wave sine lookup, amplitude scaling.
// An accepted tick fills the table read register; the output register then drives m_tvalid.
// Throughput: one sample per clock unless the output stalls; the table RAM read register
// and the output register form the two pipeline stages; a stall holds the first stage.
// Reset: registers return to their reset values, then the table RAM is loaded with its
// 2^TABLE_ADDR_BITS + 1 entries while s_tready is low; APB writes are taken throughout.
module cw_quadrature_nco_generator #(
    parameter int PHASE_BITS      = cwqnco_pkg::DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = cwqnco_pkg::DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = cwqnco_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS      = cwqnco_pkg::DEF_COUNT_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [cwqnco_pkg::IN_DATA_BITS-1:0]       s_tdata,  // [0] tick
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,  // i_sample, q_sample
    output logic                                      m_tuser,  // packet_start
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [cwqnco_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [cwqnco_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [cwqnco_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                      pready
);
    import cwqnco_pkg::*;

    localparam int OUT_DATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int ADDR_BITS     = TABLE_ADDR_BITS + 2;
    localparam int IDX_BITS      = TABLE_ADDR_BITS + 1;
    localparam int ENTRY_BITS    = SAMPLE_BITS - 1;
    localparam int PROD_BITS     = AMP_BITS + ENTRY_BITS;
    localparam int CMP_BITS      = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;

    localparam logic [ADDR_BITS-1:0] QTR_TURN = {2'b01, {TABLE_ADDR_BITS{1'b0}}};
    localparam logic [IDX_BITS-1:0]  QTR_IDX  = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

    // Mirror the index in the second and fourth quadrants
    function automatic logic [IDX_BITS-1:0] fold_idx(input logic [ADDR_BITS-1:0] a);
        logic [IDX_BITS-1:0] lo;
        lo = {1'b0, a[TABLE_ADDR_BITS-1:0]};
        return a[TABLE_ADDR_BITS] ? QTR_IDX - lo : lo;
    endfunction

    // Round amplitude * entry to Q1.15, then apply the sign
    function automatic logic [SAMPLE_BITS-1:0] scale(input logic [AMP_BITS-1:0] amp,
                                                     input logic [ENTRY_BITS-1:0] entry,
                                                     input logic neg);
        logic [PROD_BITS-1:0] prod;
        logic [SAMPLE_BITS-1:0] mag;
        prod = PROD_BITS'(amp) * PROD_BITS'(entry)
             + (PROD_BITS'(1) << (AMP_BITS - 1));
        mag  = {1'b0, prod[PROD_BITS-1:AMP_BITS]};
        return neg ? SAMPLE_BITS'(0) - mag : mag;
    endfunction

    // Configuration registers
    logic [STEP_BITS-1:0] phase_step_reg;
    logic [AMP_BITS-1:0]  amplitude_reg;
    logic [LEN_BITS-1:0]  packet_length_reg;
    logic                 cfg_wr;
    logic [REG_IDX_BITS-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= RST_PHASE_STEP;
            amplitude_reg     <= RST_AMPLITUDE;
            packet_length_reg <= RST_PACKET_LENGTH;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PHASE_STEP:    phase_step_reg    <= pwdata[STEP_BITS-1:0];
                REG_AMPLITUDE:     amplitude_reg     <= pwdata[AMP_BITS-1:0];
                REG_PACKET_LENGTH: packet_length_reg <= pwdata[LEN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PHASE_STEP:    prdata = APB_DATA_BITS'(phase_step_reg);
            REG_AMPLITUDE:     prdata = APB_DATA_BITS'(amplitude_reg);
            REG_PACKET_LENGTH: prdata = APB_DATA_BITS'(packet_length_reg);
            default:           prdata = '0;
        endcase
    end

    // Handshake and pipeline control
    logic v1_reg;
    logic v1_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic adv1;
    logic accept;
    logic fire;
    logic fill_done;

    assign adv1     = v1_reg && (!out_valid_reg || m_tready);
    assign s_tready = fill_done && (!v1_reg || adv1);
    assign accept   = s_tvalid && s_tready;
    assign fire     = accept && s_tdata[0];
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        v1_next = v1_reg;
        if (fire)
        begin
            v1_next = 1'b1;
        end
        else if (adv1)
        begin
            v1_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv1)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Phase and sample counter state
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [COUNT_BITS-1:0] sample_index_reg;
    logic [COUNT_BITS-1:0] sample_index_next;
    logic [CMP_BITS-1:0]   len_eff;
    logic [CMP_BITS-1:0]   idx_inc;

    assign len_eff = (packet_length_reg == '0) ? CMP_BITS'(1) : CMP_BITS'(packet_length_reg);
    assign idx_inc = CMP_BITS'(sample_index_reg) + CMP_BITS'(1);

    always_comb
    begin
        phase_acc_next    = phase_acc_reg;
        sample_index_next = sample_index_reg;
        if (fire)
        begin
            phase_acc_next    = phase_acc_reg + PHASE_BITS'(phase_step_reg);
            sample_index_next = (idx_inc >= len_eff) ? '0 : COUNT_BITS'(idx_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            v1_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
            v1_reg           <= v1_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Table addressing: cosine is the sine a quarter turn ahead
    logic [ADDR_BITS-1:0]  addr_q;
    logic [ADDR_BITS-1:0]  addr_i;
    logic [ENTRY_BITS-1:0] entry_i;
    logic [ENTRY_BITS-1:0] entry_q;

    assign addr_q = phase_acc_reg[PHASE_BITS-1 -: ADDR_BITS];
    assign addr_i = addr_q + QTR_TURN;

    cwqnco_table #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (fire),
        .rd_addr_a (fold_idx(addr_i)),
        .rd_addr_b (fold_idx(addr_q)),
        .rd_data_a (entry_i),
        .rd_data_b (entry_q),
        .fill_done (fill_done)
    );

    // First stage payload, loaded with the table read
    logic neg_i_reg;
    logic neg_q_reg;
    logic pstart1_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            neg_i_reg   <= addr_i[ADDR_BITS-1];
            neg_q_reg   <= addr_q[ADDR_BITS-1];
            pstart1_reg <= (sample_index_reg == '0);
        end
    end

    // Output register
    logic [SAMPLE_BITS-1:0] i_out_reg;
    logic [SAMPLE_BITS-1:0] q_out_reg;
    logic                   pstart_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            i_out_reg      <= scale(amplitude_reg, entry_i, neg_i_reg);
            q_out_reg      <= scale(amplitude_reg, entry_q, neg_q_reg);
            pstart_out_reg <= pstart1_reg;
        end
    end

    assign m_tdata = OUT_DATA_BITS'({q_out_reg, i_out_reg});
    assign m_tuser = pstart_out_reg;

`ifndef SYNTH
    a_no_accept_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
        !fill_done |-> !s_tready && !v1_reg && !m_tvalid)
        else $error("tick taken or sample produced before table load finished");

    a_phase_holds_without_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_acc_reg) && $stable(sample_index_reg))
        else $error("phase or sample counter moved without a tick");

    a_stage1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && m_tvalid && !m_tready |=> v1_reg && $stable(pstart1_reg))
        else $error("pending sample dropped while output stalled");

    a_stage1_fill_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> v1_reg)
        else $error("accepted tick did not reach the first stage");
`endif
endmodule

/* tb/cw_quadrature_nco_generator_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the quadrature NCO tone generator.
module cw_quadrature_nco_generator_test;
    import cwqnco_pkg::*;

    localparam int     QTR_SIZE      = 1024;
    localparam longint FULL_SCALE    = 64'sd32767;
    localparam longint PI_HALF_FIX   = 64'sd1686629713;
    localparam longint Q30_HALF      = 64'sd536870912;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     RANDOM_PHASES = 12;
    localparam int     TICKS_PER_PHASE = 90;

    // Unmapped register slot; writes there must be ignored
    localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = REG_IDX_BITS'(3);

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [15:0] i_val;
        logic [15:0] q_val;
        logic        start;
    } nco_sample_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata;   // [0] tick
    logic                      m_tvalid;
    logic                      m_tready;
    logic [31:0]               m_tdata;   // [15:0] i_sample, [31:16] q_sample
    logic                      m_tuser;   // [0] packet_start
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    int send_idle_pct;
    int recv_stall_pct;
    int ticks_sent;
    int empty_ticks_sent;
    int settings_written;

    cw_quadrature_nco_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    class tone_scoreboard;
        longint         quarter_sine[0:QTR_SIZE];
        logic [31:0]    step_reg;
        logic [14:0]    amp_reg;
        logic [23:0]    len_reg;
        logic [31:0]    phase_acc;
        logic [23:0]    sample_idx;
        nco_sample_t    expected_iq[$];
        int             fail_count;
        int             checked_count;
        int             start_count;

        function new();
            build_table();
            step_reg      = RST_PHASE_STEP;
            amp_reg       = RST_AMPLITUDE;
            len_reg       = RST_PACKET_LENGTH;
            phase_acc     = '0;
            sample_idx    = '0;
            fail_count    = 0;
            checked_count = 0;
            start_count   = 0;
        endfunction

        function longint round_q30(longint a, longint b);
            return (a * b + Q30_HALF) >>> 30;
        endfunction

        // Quarter-wave sine by truncated Taylor series in Q2.30
        function void build_table();
            longint x;
            longint term;
            longint sum;
            longint v;
            for (int k = 0; k <= QTR_SIZE; k++)
            begin
                x    = (PI_HALF_FIX * k + QTR_SIZE / 2) / QTR_SIZE;
                term = x;
                sum  = x;
                for (int n = 1; n <= 8; n++)
                begin
                    term = round_q30(round_q30(term, x), x) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                if (sum < 0)
                    sum = 0;
                v = (sum * FULL_SCALE + Q30_HALF) >>> 30;
                quarter_sine[k] = (v > FULL_SCALE) ? FULL_SCALE : v;
            end
        endfunction

        function logic [15:0] scaled_sine(logic [11:0] addr);
            logic [10:0] idx;
            longint      mag;
            idx = {1'b0, addr[9:0]};
            // mirror odd quadrants, negate the second half-turn
            if (addr[10])
                idx = 11'd1024 - idx;
            mag = (longint'(amp_reg) * quarter_sine[idx] + 64'sd16384) >>> 15;
            if (addr[11])
                mag = -mag;
            return mag[15:0];
        endfunction

        function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
            case (idx)
                REG_PHASE_STEP:    step_reg = value;
                REG_AMPLITUDE:     amp_reg  = value[14:0];
                REG_PACKET_LENGTH: len_reg  = value[23:0];
                default:           ;
            endcase
        endfunction

        function void note_tick(logic tick);
            nco_sample_t s;
            logic [11:0] addr;
            logic [24:0] next_idx;
            if (!tick)
                return;
            addr    = phase_acc[31:20];
            s.i_val = scaled_sine(addr + 12'd1024);
            s.q_val = scaled_sine(addr);
            s.start = (sample_idx == '0);
            expected_iq.push_back(s);
            phase_acc = phase_acc + step_reg;
            next_idx  = sample_idx + 25'd1;
            // zero length acts as one; an index reaching the length wraps to zero
            if (next_idx >= ((len_reg == '0) ? 25'd1 : {1'b0, len_reg}))
                sample_idx = '0;
            else
                sample_idx = next_idx[23:0];
        endfunction

        function void check_sample(logic [31:0] data, logic start);
            nco_sample_t e;
            checked_count++;
            if (expected_iq.size() == 0)
            begin
                $display("%0t: unexpected sample i=%0d q=%0d start=%0b", $time,
                         $signed(data[15:0]), $signed(data[31:16]), start);
                fail_count++;
                return;
            end
            e = expected_iq.pop_front();
            if (e.start)
                start_count++;
            if (data[15:0] !== e.i_val)
            begin
                $display("%0t: i_sample expected %0d got %0d", $time,
                         $signed(e.i_val), $signed(data[15:0]));
                fail_count++;
            end
            if (data[31:16] !== e.q_val)
            begin
                $display("%0t: q_sample expected %0d got %0d", $time,
                         $signed(e.q_val), $signed(data[31:16]));
                fail_count++;
            end
            if (start !== e.start)
            begin
                $display("%0t: packet_start expected %0b got %0b", $time, e.start, start);
                fail_count++;
            end
        endfunction
    endclass

    tone_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sample(m_tdata, m_tuser);
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        endcase
    endtask

    // Entered and left at a falling edge; valid stays high for a following item
    task automatic send_tick(logic tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_DATA_BITS'(tick);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_tick(tick);
        if (tick)
            ticks_sent++;
        else
            empty_ticks_sent++;
        @(negedge clk);
    endtask

    // Hold off until every sample is out, then let the pipeline settle
    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (sb.expected_iq.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_BITS'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic [31:0] step, logic [31:0] amp, logic [31:0] len);
        wait_drain();
        apb_write(REG_PHASE_STEP, step);
        apb_write(REG_AMPLITUDE, amp);
        apb_write(REG_PACKET_LENGTH, len);
        settings_written++;
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(4095);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_amplitude();
        logic [31:0] junk;
        junk = $urandom & 32'hFFFF_8000;
        case ($urandom_range(5))
            0:       return junk;
            1:       return junk | 32'd32767;
            default: return junk | $urandom_range(32767);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        logic [31:0] junk;
        junk = $urandom & 32'hFF00_0000;
        case ($urandom_range(9))
            0:       return junk;
            1:       return junk | 32'd1;
            2:       return junk | 32'd16777215;
            3:       return junk | $urandom_range(300, 50);
            default: return junk | $urandom_range(12, 1);
        endcase
    endfunction

    initial
    begin
        int phase_ticks;
        int errors;
        sb               = new();
        ticks_sent       = 0;
        empty_ticks_sent = 0;
        settings_written = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b1;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        set_idling(IDLE_NONE);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: fixed phase, full amplitude, first sample flagged
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);

        // quarter-turn steps hit every quadrant edge; zero length flags all
        configure(32'h4000_0000, 32'd32767, 32'hFF00_0000);
        repeat (8) send_tick(1'b1);

        // full-scale step, silent output, longest packet
        configure(32'hFFFF_FFFF, 32'hFFFF_8000, 32'd16777215);
        repeat (3) send_tick(1'b1);

        // off-grid step exercises mirrored indexes; unmapped write dropped
        configure(32'h4010_0000, 32'd1, 32'd3);
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            configure(pick_step(), pick_amplitude(), pick_length());
            if ($urandom_range(3) == 0)
                apb_write(REG_UNMAPPED, $urandom);
            set_idling(idle_mode_t'(ph % 4));
            phase_ticks = 0;
            while (phase_ticks < TICKS_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_tick(1'b0);
                end
                else
                begin
                    send_tick(1'b1);
                    phase_ticks++;
                end
                if ($urandom_range(79) == 0)
                    wait_drain();
            end
        end

        set_idling(IDLE_NONE);
        wait_drain();

        errors = sb.fail_count + sb.expected_iq.size();
        $display("Sent %0d sample ticks and %0d empty ticks over %0d register settings;",
                 ticks_sent, empty_ticks_sent, settings_written);
        $display("checked %0d samples, %0d of them packet starts.",
                 sb.checked_count, sb.start_count);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
